[sv/utf8ss_pkg.sv]
package utf8ss_pkg;

  // One item can expand to at most ten output bytes.
  localparam int unsigned MaxRes = 10;
  localparam int unsigned CntW   = $clog2(MaxRes + 1);

  typedef logic [7:0] byte_t;

  typedef struct packed {
    byte_t data;
    logic  last;
  } item_t;

  typedef struct packed {
    logic [MaxRes-1:0][7:0] data;
    logic [CntW-1:0]        cnt;
    logic                   last;
  } res_t;

endpackage

[sv/utf8ss_in_stage.sv]
module utf8ss_in_stage
  import utf8ss_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  input  item_t item_i,
  input  logic  consume_i,
  output logic  valid_o,
  output item_t item_o
);

  logic  valid_q;
  item_t item_q;

  assign in_ready_o = !valid_q || consume_i;
  assign valid_o    = valid_q;
  assign item_o     = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_valid_i && in_ready_o) begin
      valid_q <= 1'b1;
    end else if (consume_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q <= item_i;
    end
  end

endmodule

[sv/utf8ss_expand.sv]
module utf8ss_expand
  import utf8ss_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  item_t item_i,
  input  logic  consume_i,
  output res_t  res_o
);

  localparam byte_t Tab      = 8'h09;
  localparam byte_t Lf       = 8'h0A;
  localparam byte_t Cr       = 8'h0D;
  localparam byte_t Space    = 8'h20;
  localparam byte_t Del      = 8'h7F;
  localparam byte_t C1First  = 8'h80;
  localparam byte_t Nel      = 8'h85;
  localparam byte_t Nbsp     = 8'hA0;
  localparam byte_t LeadMin  = 8'hC0;
  localparam byte_t Pfx2     = 8'hC2;
  localparam byte_t Pfx3     = 8'hC3;
  localparam byte_t Lead3Min = 8'hE0;
  localparam byte_t Lead4Min = 8'hF0;
  localparam byte_t LeadMax  = 8'hF4;
  localparam byte_t EuroB0   = 8'hE2;
  localparam byte_t EuroB1   = 8'h82;
  localparam byte_t EuroB2   = 8'hAC;
  localparam byte_t Latin1Of = 8'h40;

  typedef struct packed {
    logic [3:0][7:0] data;
    logic [2:0]      cnt;
  } seg_t;

  typedef logic [MaxRes-1:0][7:0] list_t;

  // Bytes for a byte seen with no sequence pending; a valid lead yields none.
  function automatic seg_t lone_seg(byte_t b);
    seg_t s;
    s = '0;
    if (b < Del) begin
      if (b == Tab || b == Lf || b == Cr || b >= Space) begin
        s.data[0] = b;
        s.cnt     = 3'd1;
      end
    end else if (b < Nbsp) begin
      if (b == C1First) begin
        s.data[0] = EuroB0;
        s.data[1] = EuroB1;
        s.data[2] = EuroB2;
        s.cnt     = 3'd3;
      end else if (b == Nel) begin
        s.data[0] = Lf;
        s.data[1] = Cr;
        s.cnt     = 3'd2;
      end
    end else if (b < LeadMin) begin
      s.data[0] = Pfx2;
      s.data[1] = b;
      s.cnt     = 3'd2;
    end else if (b < Pfx2 || b > LeadMax) begin
      s.data[0] = Pfx3;
      s.data[1] = b - Latin1Of;
      s.cnt     = 3'd2;
    end
    return s;
  endfunction

  function automatic seg_t fail_head(byte_t lead);
    seg_t s;
    s = '0;
    s.data[0] = Pfx3;
    s.data[1] = lead - Latin1Of;
    s.cnt     = 3'd2;
    return s;
  endfunction

  function automatic seg_t gate(seg_t s, logic en);
    seg_t g;
    g = s;
    if (!en) begin
      g.cnt = 3'd0;
    end
    return g;
  endfunction

  // Places a segment at position pos of the list.
  function automatic list_t place(list_t l, logic [CntW-1:0] pos, seg_t s);
    list_t r;
    r = l;
    for (int k = 0; k < MaxRes; k++) begin
      for (int j = 0; j < 4; j++) begin
        if (3'(j) < s.cnt && CntW'(k) == pos + CntW'(j)) begin
          r[k] = s.data[j];
        end
      end
    end
    return r;
  endfunction

  byte_t           lead_q, lead_d;
  byte_t [1:0]     hold_q, hold_d;
  logic  [1:0]     hcnt_q, hcnt_d;
  logic  [2:0]     slen_q, slen_d;

  byte_t           b;
  logic            cont, pend, broken, complete, keep, drop_c2, opens, flush;
  byte_t           lead1;
  byte_t [1:0]     hold1;
  logic  [1:0]     hcnt1;
  logic  [2:0]     slen1, open_len;
  seg_t  [7:0]     seg;
  seg_t            whole;
  list_t           list;
  logic  [CntW-1:0] pos;

  always_comb begin
    b        = item_i.data;
    cont     = (b[7:6] == 2'b10);
    pend     = (slen_q != 3'd0);
    broken   = pend && !cont;
    complete = pend && cont && ({1'b0, hcnt_q} + 3'd2 >= slen_q);
    keep     = pend && cont && !complete;
    drop_c2  = (slen_q == 3'd2) && (lead_q == Pfx2) && (b < Nbsp);
    opens    = (!pend || broken) && (b >= Pfx2) && (b <= LeadMax);
    open_len = (b < Lead3Min) ? 3'd2 : ((b < Lead4Min) ? 3'd3 : 3'd4);

    lead1 = lead_q;
    hold1 = hold_q;
    hcnt1 = hcnt_q;
    slen1 = slen_q;
    if (opens) begin
      lead1 = b;
      hcnt1 = 2'd0;
      slen1 = open_len;
    end else if (complete || broken) begin
      hcnt1 = 2'd0;
      slen1 = 3'd0;
    end else if (keep) begin
      hold1[hcnt_q[0]] = b;
      hcnt1            = hcnt_q + 2'd1;
    end
    flush = item_i.last && (slen1 != 3'd0);

    // A completed sequence passes as lead, held continuations, then this byte.
    whole = '0;
    whole.data[0] = lead_q;
    case (hcnt_q)
      2'd0: begin
        whole.data[1] = b;
      end
      2'd1: begin
        whole.data[1] = hold_q[0];
        whole.data[2] = b;
      end
      default: begin
        whole.data[1] = hold_q[0];
        whole.data[2] = hold_q[1];
        whole.data[3] = b;
      end
    endcase
    whole.cnt = {1'b0, hcnt_q} + 3'd2;

    seg[0] = gate(fail_head(lead_q), broken);
    seg[1] = gate(lone_seg(hold_q[0]), broken && hcnt_q >= 2'd1);
    seg[2] = gate(lone_seg(hold_q[1]), broken && hcnt_q >= 2'd2);
    seg[3] = gate(lone_seg(b), !pend || broken);
    seg[4] = gate(whole, complete && !drop_c2);
    seg[5] = gate(fail_head(lead1), flush);
    seg[6] = gate(lone_seg(hold1[0]), flush && hcnt1 >= 2'd1);
    seg[7] = gate(lone_seg(hold1[1]), flush && hcnt1 >= 2'd2);

    list = '0;
    pos  = '0;
    for (int i = 0; i < 8; i++) begin
      list = place(list, pos, seg[i]);
      pos  = pos + CntW'(seg[i].cnt);
    end

    res_o.data = list;
    res_o.cnt  = pos;
    res_o.last = item_i.last;

    lead_d = lead1;
    hold_d = hold1;
    hcnt_d = flush ? 2'd0 : hcnt1;
    slen_d = flush ? 3'd0 : slen1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lead_q <= '0;
      hold_q <= '0;
      hcnt_q <= '0;
      slen_q <= '0;
    end else if (consume_i) begin
      lead_q <= lead_d;
      hold_q <= hold_d;
      hcnt_q <= hcnt_d;
      slen_q <= slen_d;
    end
  end

endmodule

[sv/utf8ss_out_buffer.sv]
module utf8ss_out_buffer
  import utf8ss_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  load_i,
  input  res_t  res_i,
  output logic  load_ready_o,
  output logic  out_valid_o,
  input  logic  out_ready_i,
  output byte_t out_byte_o,
  output logic  byte_valid_o,
  output logic  run_last_o,
  output logic  string_end_o
);

  logic [MaxRes-1:0][7:0] data_q;
  logic [CntW-1:0]        cnt_q;
  logic [CntW-1:0]        idx_q;
  logic                   last_q;
  logic                   bvalid_q;
  logic                   valid_q;
  logic                   fin;
  logic                   pop;
  logic                   empty_res;

  assign fin          = (idx_q == cnt_q - CntW'(1));
  assign pop          = valid_q && out_ready_i;
  assign load_ready_o = !valid_q || (pop && fin);
  assign empty_res    = (res_i.cnt == '0);

  assign out_valid_o  = valid_q;
  assign out_byte_o   = data_q[idx_q];
  assign byte_valid_o = bvalid_q;
  assign run_last_o   = fin;
  assign string_end_o = fin && last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= 1'b0;
      idx_q    <= '0;
      cnt_q    <= '0;
      last_q   <= 1'b0;
      bvalid_q <= 1'b0;
    end else if (load_i) begin
      valid_q  <= 1'b1;
      idx_q    <= '0;
      // An item that closes the string with no byte leaves one empty marker.
      cnt_q    <= empty_res ? CntW'(1) : res_i.cnt;
      last_q   <= res_i.last;
      bvalid_q <= !empty_res;
    end else if (pop && fin) begin
      valid_q <= 1'b0;
    end else if (pop) begin
      idx_q <= idx_q + CntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= res_i.data;
    end
  end

endmodule

[sv/utf8_stream_sanitizer_unit.sv]
// Channel | Direction | Handshake             | Payload
// input   | in        | in_valid_i/in_ready_o   | in_byte_i[7:0], is_last_i
// output  | out       | out_valid_o/out_ready_i | out_byte_o[7:0], byte_valid_o,
//         |           |                         | run_last_o, string_end_o
//
// An item is registered on entry and expanded into up to ten bytes, which are
// loaded into the result register when it is free; the first byte is driven
// onto the output from that register.
// The output port sends one byte per cycle while out_ready_i is high, so an
// item that yields n bytes (n from 1 to 10) holds the output until all n are
// sent; items that yield one byte or none flow at one item per cycle while it stays high.
// Reset clears any pending multi-byte sequence and empties both stages.
// A stalled output holds the next item in the input register.
module utf8_stream_sanitizer_unit
  import utf8ss_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_byte_i,
  input  logic       is_last_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic       byte_valid_o,
  output logic       run_last_o,
  output logic       string_end_o
);

  item_t item_in;
  item_t item_q;
  logic  stage_valid;
  logic  load_ready;
  logic  consume;
  logic  load;
  res_t  res;

  assign item_in.data = in_byte_i;
  assign item_in.last = is_last_i;

  assign consume = stage_valid && load_ready;
  // A non-final item that yields no byte is consumed without a result.
  assign load    = consume && (res.cnt != '0 || res.last);

  utf8ss_in_stage u_in_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .item_i     (item_in),
    .consume_i  (consume),
    .valid_o    (stage_valid),
    .item_o     (item_q)
  );

  utf8ss_expand u_expand (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .item_i    (item_q),
    .consume_i (consume),
    .res_o     (res)
  );

  utf8ss_out_buffer u_out_buffer (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_i       (load),
    .res_i        (res),
    .load_ready_o (load_ready),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_byte_o   (out_byte_o),
    .byte_valid_o (byte_valid_o),
    .run_last_o   (run_last_o),
    .string_end_o (string_end_o)
  );

`ifndef SYNTHESIS
  a_marker_closes : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !byte_valid_o |-> run_last_o && string_end_o && out_byte_o == 8'h00)
    else $error("empty marker must close the string");

  a_end_is_run_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && string_end_o |-> run_last_o)
    else $error("string end on a result that is not the last of its item");

  a_stage_held : assert property (@(posedge clk_i) disable iff (!rst_ni)
    stage_valid && !load_ready |=> stage_valid && $stable(item_q))
    else $error("registered item lost while the output is busy");

  a_no_load_when_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |-> !out_valid_o || (out_ready_i && run_last_o))
    else $error("result buffer overwritten before it was drained");
`endif

endmodule
